// File: design/bcl_pkg.sv
// Shared types and constants for the battery capacity lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package bcl_pkg;

  localparam int unsigned VoltageRows = 16;
  localparam int unsigned CurrentCols = 16;
  localparam int unsigned Depth       = VoltageRows * CurrentCols;
  localparam int unsigned AddrW       = $clog2(Depth);
  localparam int unsigned RIdxW       = $clog2(VoltageRows);
  localparam int unsigned CIdxW       = $clog2(CurrentCols);
  localparam int unsigned SIdxW       = (RIdxW > CIdxW) ? RIdxW : CIdxW;

  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 4;
  localparam int unsigned MvW     = 16;
  localparam int unsigned MaW     = 18;
  localparam int unsigned MahW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CapW    = 24;
  localparam int unsigned FracW   = 8;

  // capacity values through the current stage stay well inside this width
  localparam int unsigned YW   = 48;
  // product and quotient width
  localparam int unsigned PW   = 64;
  localparam int unsigned CntW = $clog2(PW);
  localparam int unsigned MulSteps = MaW;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusBelow = 2'd1;
  localparam logic [StatusW-1:0] StatusAbove = 2'd2;

  localparam logic FuncWrite = 1'b0;

  typedef struct packed {
    logic             func;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [MvW-1:0]   volts_mv;
    logic [MaW-1:0]   amps_ma;
    logic [MahW-1:0]  entry_mah;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CapW-1:0]    capacity_q8;
  } out_item_t;

  typedef struct packed {
    logic [MvW-1:0]  mv;
    logic [MaW-1:0]  ma;
    logic [MahW-1:0] mah;
  } grid_entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_RD_COL,
    OP_CMP_COL,
    OP_RD_ROW,
    OP_CMP_ROW,
    OP_RD_A,
    OP_CAP_A,
    OP_RD_B,
    OP_CAP_B,
    OP_LD_CUR,
    OP_LD_VOLT,
    OP_MUL,
    OP_DIV,
    OP_FIN_CUR,
    OP_FIN_VOLT,
    OP_PUSH
  } dp_op_e;

  typedef enum logic [1:0] {
    PH_LO,
    PH_HI,
    PH_VOLT
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL_RD,
    S_COL_CMP,
    S_ROW_RD,
    S_ROW_CMP,
    S_RD_A,
    S_CAP_A,
    S_RD_B,
    S_CAP_B,
    S_LD,
    S_MUL,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic   take;
    logic   upper;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic hit;
    logic below;
    logic last;
    logic col_above;
    logic mul_last;
    logic div_last;
  } sts_t;

  function automatic logic [AddrW-1:0] grid_addr(input logic [RIdxW-1:0] r,
                                                 input logic [CIdxW-1:0] c);
    return AddrW'(int'(r) * CurrentCols + int'(c));
  endfunction

endpackage

`default_nettype wire

// File: design/bcl_in_if.sv
// Input item channel: valid/ready handshake with query or grid write payload.
`timescale 1ns / 1ps
`default_nettype none

interface bcl_in_if;
  logic              valid;
  logic              ready;
  bcl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/bcl_out_if.sv
// Result item channel: valid/ready handshake with status and capacity payload.
`timescale 1ns / 1ps
`default_nettype none

interface bcl_out_if;
  logic               valid;
  logic               ready;
  bcl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/bcl_dpath.sv
// Datapath: grid memory, search compare, serial multiply/divide interpolation.
`timescale 1ns / 1ps
`default_nettype none

module bcl_dpath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bcl_pkg::cmd_t       cmd_i,
  input  bcl_pkg::in_item_t   in_data_i,
  output bcl_pkg::sts_t       sts_o,
  output bcl_pkg::out_item_t  res_o
);

  bcl_pkg::grid_entry_t mem [bcl_pkg::Depth];
  bcl_pkg::grid_entry_t rd_q;

  logic [bcl_pkg::MvW-1:0]   q_mv_q;
  logic [bcl_pkg::MaW-1:0]   q_ma_q;
  logic [bcl_pkg::SIdxW-1:0] idx_q;
  logic [bcl_pkg::CIdxW-1:0] col_q;
  logic [bcl_pkg::RIdxW-1:0] row_q;
  logic                      col_above_q;

  bcl_pkg::grid_entry_t p0_q, p1_q;
  logic signed [bcl_pkg::YW-1:0] cap_lo_q, cap_hi_q, y0_q;
  logic [bcl_pkg::MvW-1:0] mv_lo_q, mv_hi_q;

  logic [bcl_pkg::MaW-1:0]  mplier_q, den_q, rem_q;
  logic [bcl_pkg::PW-1:0]   mcand_q, acc_q;
  logic                     neg_q, den_zero_q;
  logic [bcl_pkg::CntW-1:0] cnt_q;

  logic [bcl_pkg::StatusW-1:0] res_status_q;
  logic [bcl_pkg::CapW-1:0]    res_cap_q;
  bcl_pkg::out_item_t          out_q;

  logic                     wr_en, rd_en, in_range;
  logic [bcl_pkg::AddrW-1:0] wr_addr, rd_addr;
  logic [bcl_pkg::RIdxW-1:0] pair_row;

  logic                     is_row;
  logic                     cmp_hit, cmp_below, cmp_last;

  logic [bcl_pkg::MaW-1:0]        ld_x, ld_x0, ld_x1;
  logic signed [bcl_pkg::YW-1:0]  ld_y0, ld_y1, ld_dy;
  logic [bcl_pkg::MaW:0]          ld_dx, ld_den, dx_abs, den_abs;
  logic [bcl_pkg::YW-1:0]         dy_abs;

  logic [bcl_pkg::MaW:0]  rem_sh;
  logic                   div_bit;
  logic [bcl_pkg::PW-1:0] quot_s, fin_sum;
  logic [bcl_pkg::CapW-1:0] sat_cap;

  // Memory write and read ports
  assign in_range = (int'(in_data_i.row) < bcl_pkg::VoltageRows) &&
                    (int'(in_data_i.col) < bcl_pkg::CurrentCols);
  assign wr_en    = cmd_i.take && (in_data_i.func == bcl_pkg::FuncWrite) && in_range;
  assign wr_addr  = bcl_pkg::grid_addr(bcl_pkg::RIdxW'(in_data_i.row),
                                       bcl_pkg::CIdxW'(in_data_i.col));
  assign pair_row = row_q + bcl_pkg::RIdxW'(cmd_i.upper);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd_i.op)
      bcl_pkg::OP_RD_COL: rd_addr = bcl_pkg::grid_addr('0, bcl_pkg::CIdxW'(idx_q));
      bcl_pkg::OP_RD_ROW: rd_addr = bcl_pkg::grid_addr(bcl_pkg::RIdxW'(idx_q), '0);
      bcl_pkg::OP_RD_A:   rd_addr = bcl_pkg::grid_addr(pair_row, col_q);
      bcl_pkg::OP_RD_B:   rd_addr = bcl_pkg::grid_addr(pair_row, col_q + 1'b1);
      default:            rd_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{mv: in_data_i.volts_mv, ma: in_data_i.amps_ma,
                        mah: in_data_i.entry_mah};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Search compare on the entry just read
  assign is_row = (cmd_i.op == bcl_pkg::OP_CMP_ROW);
  always_comb begin
    if (is_row) begin
      cmp_hit  = rd_q.mv >= q_mv_q;
      cmp_last = idx_q == bcl_pkg::SIdxW'(bcl_pkg::VoltageRows - 1);
    end else begin
      cmp_hit  = rd_q.ma >= q_ma_q;
      cmp_last = idx_q == bcl_pkg::SIdxW'(bcl_pkg::CurrentCols - 1);
    end
    cmp_below = (idx_q == '0) && !(is_row ? (rd_q.mv == q_mv_q) : (rd_q.ma == q_ma_q))
                && cmp_hit;
  end

  // Interpolation operands
  always_comb begin
    if (cmd_i.op == bcl_pkg::OP_LD_VOLT) begin
      ld_x  = bcl_pkg::MaW'(q_mv_q);
      ld_x0 = bcl_pkg::MaW'(mv_lo_q);
      ld_x1 = bcl_pkg::MaW'(mv_hi_q);
      ld_y0 = cap_lo_q;
      ld_y1 = cap_hi_q;
    end else begin
      ld_x  = q_ma_q;
      ld_x0 = p0_q.ma;
      ld_x1 = p1_q.ma;
      ld_y0 = bcl_pkg::YW'({p0_q.mah, {bcl_pkg::FracW{1'b0}}});
      ld_y1 = bcl_pkg::YW'({p1_q.mah, {bcl_pkg::FracW{1'b0}}});
    end
    ld_dx   = {1'b0, ld_x} - {1'b0, ld_x0};
    ld_den  = {1'b0, ld_x1} - {1'b0, ld_x0};
    ld_dy   = ld_y1 - ld_y0;
    dx_abs  = ld_dx[bcl_pkg::MaW] ? (~ld_dx + 1'b1) : ld_dx;
    den_abs = ld_den[bcl_pkg::MaW] ? (~ld_den + 1'b1) : ld_den;
    dy_abs  = ld_dy[bcl_pkg::YW-1] ? (~ld_dy + 1'b1) : ld_dy;
  end

  // Restoring divide step and final correction
  always_comb begin
    rem_sh  = {rem_q, acc_q[bcl_pkg::PW-1]};
    div_bit = rem_sh >= {1'b0, den_q};
    quot_s  = neg_q ? (~acc_q + 1'b1) : acc_q;
    fin_sum = {{(bcl_pkg::PW - bcl_pkg::YW){y0_q[bcl_pkg::YW-1]}}, y0_q};
    if (!den_zero_q) begin
      fin_sum = fin_sum + quot_s;
    end
    if (fin_sum[bcl_pkg::PW-1]) begin
      sat_cap = '0;
    end else if (|fin_sum[bcl_pkg::PW-2:bcl_pkg::CapW]) begin
      sat_cap = '1;
    end else begin
      sat_cap = fin_sum[bcl_pkg::CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      col_above_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.take) begin
        idx_q       <= '0;
        col_above_q <= 1'b0;
      end
      case (cmd_i.op)
        bcl_pkg::OP_CMP_COL: begin
          idx_q <= (cmp_hit || cmp_last) ? '0 : idx_q + 1'b1;
          if (cmp_last && !cmp_hit) begin
            col_above_q <= 1'b1;
          end
        end
        bcl_pkg::OP_CMP_ROW: idx_q <= (cmp_hit || cmp_last) ? '0 : idx_q + 1'b1;
        bcl_pkg::OP_LD_CUR, bcl_pkg::OP_LD_VOLT: cnt_q <= '0;
        bcl_pkg::OP_MUL: begin
          cnt_q <= sts_o.mul_last ? '0 : cnt_q + 1'b1;
        end
        bcl_pkg::OP_DIV: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      q_mv_q       <= in_data_i.volts_mv;
      q_ma_q       <= in_data_i.amps_ma;
      res_status_q <= bcl_pkg::StatusOk;
      res_cap_q    <= '0;
    end
    case (cmd_i.op)
      bcl_pkg::OP_CMP_COL: begin
        if (cmp_below) begin
          res_status_q <= bcl_pkg::StatusBelow;
        end
        if (cmp_hit) begin
          col_q <= (idx_q == '0) ? '0 : bcl_pkg::CIdxW'(idx_q - 1'b1);
        end
      end
      bcl_pkg::OP_CMP_ROW: begin
        if (cmp_below) begin
          res_status_q <= bcl_pkg::StatusBelow;
        end else if (col_above_q || (cmp_last && !cmp_hit)) begin
          res_status_q <= bcl_pkg::StatusAbove;
        end
        if (cmp_hit) begin
          row_q <= (idx_q == '0) ? '0 : bcl_pkg::RIdxW'(idx_q - 1'b1);
        end
      end
      bcl_pkg::OP_CAP_A: p0_q <= rd_q;
      bcl_pkg::OP_CAP_B: p1_q <= rd_q;
      bcl_pkg::OP_LD_CUR, bcl_pkg::OP_LD_VOLT: begin
        y0_q       <= ld_y0;
        mplier_q   <= dx_abs[bcl_pkg::MaW-1:0];
        mcand_q    <= bcl_pkg::PW'(dy_abs);
        den_q      <= den_abs[bcl_pkg::MaW-1:0];
        den_zero_q <= (ld_den == '0);
        neg_q      <= ld_dx[bcl_pkg::MaW] ^ ld_dy[bcl_pkg::YW-1] ^ ld_den[bcl_pkg::MaW];
        acc_q      <= '0;
        rem_q      <= '0;
      end
      bcl_pkg::OP_MUL: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q  <= {mcand_q[bcl_pkg::PW-2:0], 1'b0};
        mplier_q <= mplier_q >> 1;
      end
      bcl_pkg::OP_DIV: begin
        rem_q <= div_bit ? bcl_pkg::MaW'(rem_sh - {1'b0, den_q})
                         : rem_sh[bcl_pkg::MaW-1:0];
        acc_q <= {acc_q[bcl_pkg::PW-2:0], div_bit};
      end
      bcl_pkg::OP_FIN_CUR: begin
        if (cmd_i.upper) begin
          cap_hi_q <= fin_sum[bcl_pkg::YW-1:0];
          mv_hi_q  <= p0_q.mv;
        end else begin
          cap_lo_q <= fin_sum[bcl_pkg::YW-1:0];
          mv_lo_q  <= p0_q.mv;
        end
      end
      bcl_pkg::OP_FIN_VOLT: res_cap_q <= sat_cap;
      bcl_pkg::OP_PUSH: out_q <= '{status: res_status_q, capacity_q8: res_cap_q};
      default: ;
    endcase
  end

  always_comb begin
    sts_o.is_query  = in_data_i.func != bcl_pkg::FuncWrite;
    sts_o.hit       = cmp_hit;
    sts_o.below     = cmp_below;
    sts_o.last      = cmp_last;
    sts_o.col_above = col_above_q;
    sts_o.mul_last  = cnt_q == bcl_pkg::CntW'(bcl_pkg::MulSteps - 1);
    sts_o.div_last  = cnt_q == bcl_pkg::CntW'(bcl_pkg::PW - 1);
  end

  assign res_o = out_q;

endmodule

`default_nettype wire

// File: design/bcl_ctrl.sv
// Controller: sequences search, entry reads and the three interpolations.
`timescale 1ns / 1ps
`default_nettype none

module bcl_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  input  bcl_pkg::sts_t  sts_i,
  output bcl_pkg::cmd_t  cmd_o
);

  bcl_pkg::state_e state_q, state_d;
  bcl_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcl_pkg::S_IDLE;
      phase_q     <= bcl_pkg::PH_LO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.take  = 1'b0;
    cmd_o.upper = (phase_q == bcl_pkg::PH_HI);
    cmd_o.op    = bcl_pkg::OP_NONE;

    case (state_q)
      bcl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          phase_d    = bcl_pkg::PH_LO;
          state_d    = sts_i.is_query ? bcl_pkg::S_COL_RD : bcl_pkg::S_PUSH;
        end
      end
      bcl_pkg::S_COL_RD: begin
        cmd_o.op = bcl_pkg::OP_RD_COL;
        state_d  = bcl_pkg::S_COL_CMP;
      end
      bcl_pkg::S_COL_CMP: begin
        cmd_o.op = bcl_pkg::OP_CMP_COL;
        if (sts_i.below) begin
          state_d = bcl_pkg::S_PUSH;
        end else if (sts_i.hit || sts_i.last) begin
          state_d = bcl_pkg::S_ROW_RD;
        end else begin
          state_d = bcl_pkg::S_COL_RD;
        end
      end
      bcl_pkg::S_ROW_RD: begin
        cmd_o.op = bcl_pkg::OP_RD_ROW;
        state_d  = bcl_pkg::S_ROW_CMP;
      end
      bcl_pkg::S_ROW_CMP: begin
        cmd_o.op = bcl_pkg::OP_CMP_ROW;
        if (sts_i.below) begin
          state_d = bcl_pkg::S_PUSH;
        end else if (sts_i.hit) begin
          state_d = sts_i.col_above ? bcl_pkg::S_PUSH : bcl_pkg::S_RD_A;
        end else if (sts_i.last) begin
          state_d = bcl_pkg::S_PUSH;
        end else begin
          state_d = bcl_pkg::S_ROW_RD;
        end
      end
      bcl_pkg::S_RD_A: begin
        cmd_o.op = bcl_pkg::OP_RD_A;
        state_d  = bcl_pkg::S_CAP_A;
      end
      bcl_pkg::S_CAP_A: begin
        cmd_o.op = bcl_pkg::OP_CAP_A;
        state_d  = bcl_pkg::S_RD_B;
      end
      bcl_pkg::S_RD_B: begin
        cmd_o.op = bcl_pkg::OP_RD_B;
        state_d  = bcl_pkg::S_CAP_B;
      end
      bcl_pkg::S_CAP_B: begin
        cmd_o.op = bcl_pkg::OP_CAP_B;
        state_d  = bcl_pkg::S_LD;
      end
      bcl_pkg::S_LD: begin
        cmd_o.op = (phase_q == bcl_pkg::PH_VOLT) ? bcl_pkg::OP_LD_VOLT : bcl_pkg::OP_LD_CUR;
        state_d  = bcl_pkg::S_MUL;
      end
      bcl_pkg::S_MUL: begin
        cmd_o.op = bcl_pkg::OP_MUL;
        if (sts_i.mul_last) begin
          state_d = bcl_pkg::S_DIV;
        end
      end
      bcl_pkg::S_DIV: begin
        cmd_o.op = bcl_pkg::OP_DIV;
        if (sts_i.div_last) begin
          state_d = bcl_pkg::S_FIN;
        end
      end
      bcl_pkg::S_FIN: begin
        case (phase_q)
          bcl_pkg::PH_LO: begin
            cmd_o.op = bcl_pkg::OP_FIN_CUR;
            phase_d  = bcl_pkg::PH_HI;
            state_d  = bcl_pkg::S_RD_A;
          end
          bcl_pkg::PH_HI: begin
            cmd_o.op = bcl_pkg::OP_FIN_CUR;
            phase_d  = bcl_pkg::PH_VOLT;
            state_d  = bcl_pkg::S_LD;
          end
          default: begin
            cmd_o.op = bcl_pkg::OP_FIN_VOLT;
            state_d  = bcl_pkg::S_PUSH;
          end
        endcase
      end
      bcl_pkg::S_PUSH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = bcl_pkg::OP_PUSH;
          out_valid_d = 1'b1;
          state_d     = bcl_pkg::S_IDLE;
        end
      end
      default: state_d = bcl_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/battery_capacity_bilinear_lookup_unit.sv
// Top level: battery capacity lookup by bilinear interpolation over a loaded grid.
// Write item: after acceptance the unit moves to its push state, registers the result and then
// returns to idle for the next item. Query item: column search and row search each visit up to 16
// grid points with a read state and a compare state per point, then entry reads and three
// interpolations (18-step serial multiply, 64-step restoring divide) before the push state;
// one item in flight, a held result adds stalls.
// Reset clears control state only; grid contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module battery_capacity_bilinear_lookup_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  bcl_in_if.sink     in_i,
  bcl_out_if.source  out_o
);

  bcl_pkg::cmd_t cmd;
  bcl_pkg::sts_t sts;

  bcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcl_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_i.data),
    .sts_o     (sts),
    .res_o     (out_o.data)
  );

endmodule

`default_nettype wire

// File: verif/battery_capacity_bilinear_lookup_unit_tb.sv
// Testbench for the battery capacity lookup unit: random grids and queries checked in order.
`timescale 1ns / 1ps

module battery_capacity_bilinear_lookup_unit_tb;
  import bcl_pkg::*;

  localparam int SrchBelow = -1;
  localparam int SrchAbove = -2;
  localparam longint CapMax = 64'd16777215;

  logic clk_i;
  logic rst_ni;

  bcl_in_if  in_if ();
  bcl_out_if out_if ();

  battery_capacity_bilinear_lookup_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // item stream and results still owed by the block
  in_item_t  pending_items[$];
  out_item_t cap_due[$];

  // grid as the predictor sees it
  logic [MvW-1:0]  tbl_mv [VoltageRows][CurrentCols];
  logic [MaW-1:0]  tbl_ma [VoltageRows][CurrentCols];
  logic [MahW-1:0] tbl_mah[VoltageRows][CurrentCols];

  // grid as the stimulus generator knows it
  logic [MvW-1:0]  gen_mv [VoltageRows][CurrentCols];
  logic [MaW-1:0]  gen_ma [VoltageRows][CurrentCols];

  int n_taken, n_done, n_mism, n_orphan;
  int n_wr, n_ok, n_below, n_above;
  int tx_idle, rx_idle;
  logic hold_off;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint lerp_q(longint x, longint x0, longint x1, longint y0,
                                    longint y1);
    longint den;
    den = x1 - x0;
    if (den == 0) return y0;
    return y0 + ((x - x0) * (y1 - y0)) / den;
  endfunction

  function automatic longint cap_along_current(int r, int c, longint ma);
    return lerp_q(ma, longint'(tbl_ma[r][c]), longint'(tbl_ma[r][c+1]),
                  longint'(tbl_mah[r][c]) * 256, longint'(tbl_mah[r][c+1]) * 256);
  endfunction

  function automatic out_item_t predict_capacity(in_item_t it);
    out_item_t res;
    int c, r, i;
    longint lo, hi, cap;
    res = '0;
    if (it.func == FuncWrite) begin
      tbl_mv[it.row][it.col]  = it.volts_mv;
      tbl_ma[it.row][it.col]  = it.amps_ma;
      tbl_mah[it.row][it.col] = it.entry_mah;
      return res;
    end
    if (tbl_ma[0][0] > it.amps_ma) begin
      c = SrchBelow;
    end else begin
      c = SrchAbove;
      for (i = 0; i < CurrentCols; i++)
        if (c == SrchAbove && tbl_ma[0][i] >= it.amps_ma) c = (i == 0) ? 0 : i - 1;
    end
    if (tbl_mv[0][0] > it.volts_mv) begin
      r = SrchBelow;
    end else begin
      r = SrchAbove;
      for (i = 0; i < VoltageRows; i++)
        if (r == SrchAbove && tbl_mv[i][0] >= it.volts_mv) r = (i == 0) ? 0 : i - 1;
    end
    if (c == SrchBelow || r == SrchBelow) begin
      res.status = StatusBelow;
      return res;
    end
    if (c == SrchAbove || r == SrchAbove) begin
      res.status = StatusAbove;
      return res;
    end
    lo  = cap_along_current(r, c, longint'(it.amps_ma));
    hi  = cap_along_current(r + 1, c, longint'(it.amps_ma));
    cap = lerp_q(longint'(it.volts_mv), longint'(tbl_mv[r][c]), longint'(tbl_mv[r+1][c]),
                 lo, hi);
    if (cap < 0) cap = 0;
    if (cap > CapMax) cap = CapMax;
    res.status      = StatusOk;
    res.capacity_q8 = cap[CapW-1:0];
    return res;
  endfunction

  task automatic queue_write(int r, int c, logic [MvW-1:0] mv, logic [MaW-1:0] ma,
                             logic [MahW-1:0] mah);
    in_item_t it;
    it           = '0;
    it.func      = FuncWrite;
    it.row       = RowW'(r);
    it.col       = ColW'(c);
    it.volts_mv  = mv;
    it.amps_ma   = ma;
    it.entry_mah = mah;
    gen_mv[r][c] = mv;
    gen_ma[r][c] = ma;
    pending_items.push_back(it);
  endtask

  task automatic queue_query(logic [MvW-1:0] mv, logic [MaW-1:0] ma);
    in_item_t it;
    it          = '0;
    it.func     = ~FuncWrite;
    it.volts_mv = mv;
    it.amps_ma  = ma;
    // unused fields carry noise
    it.row       = RowW'($urandom);
    it.col       = ColW'($urandom);
    it.entry_mah = MahW'($urandom);
    pending_items.push_back(it);
  endtask

  // Fill every entry: voltage rises by row, current by column, with small skew.
  task automatic load_grid(int mv0, int dmv, int ma0, int dma);
    int r, c;
    for (r = 0; r < VoltageRows; r++)
      for (c = 0; c < CurrentCols; c++)
        queue_write(r, c, MvW'(mv0 + r * dmv + c * $urandom_range(4)),
                    MaW'(ma0 + c * dma + r * $urandom_range(2)), MahW'($urandom));
  endtask

  task automatic load_random_grid();
    int dmv, dma;
    dmv = $urandom_range(4000, 1);
    dma = $urandom_range(17000, 1);
    load_grid($urandom_range(65535 - 15 * dmv - 64), dmv,
              $urandom_range(262143 - 15 * dma - 40), dma);
  endtask

  task automatic queue_inside_query();
    int r, c;
    r = $urandom_range(VoltageRows - 2);
    c = $urandom_range(CurrentCols - 2);
    queue_query(MvW'($urandom_range(gen_mv[r+1][0], gen_mv[r][0])),
                MaW'($urandom_range(gen_ma[0][c+1], gen_ma[0][c])));
  endtask

  task automatic queue_random_items(int count);
    int i, pick, r, c;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      r = $urandom_range(VoltageRows - 1);
      c = $urandom_range(CurrentCols - 1);
      if (pick < 65) begin
        queue_inside_query();
      end else if (pick < 75) begin
        queue_query(MvW'($urandom), MaW'($urandom));
      end else if (pick < 80) begin
        // just off the low corner
        queue_query(gen_mv[0][0] - MvW'($urandom_range(1)), gen_ma[0][0] - MaW'($urandom_range(1)));
      end else if (pick < 92) begin
        // nudge one entry: keeps the grid mostly ordered but skews spans
        queue_write(r, c, gen_mv[r][c] + MvW'($urandom_range(30)) - MvW'(15),
                    gen_ma[r][c] + MaW'($urandom_range(30)) - MaW'(15), MahW'($urandom));
      end else if (pick < 96) begin
        // copy a neighbor's coordinate to flatten a span
        if (c > 0) queue_write(r, c, gen_mv[r][c], gen_ma[r][c-1], MahW'($urandom));
        else if (r > 0) queue_write(r, c, gen_mv[r-1][c], gen_ma[r][c], MahW'($urandom));
        else queue_write(r, c, gen_mv[r][c], gen_ma[r][c], MahW'($urandom));
      end else begin
        queue_write(r, c, MvW'($urandom), MaW'($urandom), MahW'($urandom));
      end
    end
  endtask

  // idling plan follows progress through the item stream
  always_comb begin
    if (n_taken < 350) begin
      tx_idle = 26;
      rx_idle = 87;
    end else if (n_taken < 700) begin
      tx_idle = 87;
      rx_idle = 26;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_items.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= !hold_off && ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        cap_due.push_back(predict_capacity(in_if.data));
        n_taken <= n_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        n_done <= n_done + 1;
        if (cap_due.size() == 0) begin
          n_orphan <= n_orphan + 1;
          $display("unexpected result: status %0d capacity %0d", out_if.data.status,
                   out_if.data.capacity_q8);
        end else begin
          want = cap_due.pop_front();
          if (want.status == StatusOk && want.capacity_q8 == 0) n_wr <= n_wr + 1;
          else if (want.status == StatusOk) n_ok <= n_ok + 1;
          else if (want.status == StatusBelow) n_below <= n_below + 1;
          else n_above <= n_above + 1;
          if (out_if.data.status !== want.status ||
              out_if.data.capacity_q8 !== want.capacity_q8) begin
            if (n_mism < 10)
              $display("mismatch at result %0d: status %0d/%0d capacity %0d/%0d (exp/act)",
                       n_done, want.status, out_if.data.status, want.capacity_q8,
                       out_if.data.capacity_q8);
            n_mism <= n_mism + 1;
          end
        end
      end
    end
  end

  // hold the result side off long enough for the input to back up
  initial begin
    hold_off = 1'b0;
    wait (n_taken >= 900);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #40_000_000;
    $display("battery_capacity_bilinear_lookup_unit_tb failed");
    $finish;
  end

  initial begin
    int total;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    n_taken = 0; n_done = 0; n_mism = 0; n_orphan = 0;
    n_wr = 0; n_ok = 0; n_below = 0; n_above = 0;
    rst_ni = 1'b0;

    // known grid, then corners and special cases
    load_grid(3000, 200, 0, 1000);
    queue_query(MvW'(3000), MaW'(0));
    queue_query(MvW'(3000 + 7 * 200), MaW'(5 * 1000 + 1));
    queue_query(MvW'(3100), MaW'(500));
    queue_query(MvW'(2999), MaW'(500));
    queue_query(MvW'(65535), MaW'(500));
    queue_query(MvW'(3100), MaW'(262143));
    queue_query(MvW'(0), MaW'(262143));
    queue_query(MvW'(3000 + 15 * 200), MaW'(15 * 1000 + 31));
    // flat current span in row 1, flat voltage span in column 2
    queue_write(1, 3, gen_mv[1][3], gen_ma[1][2], 16'd4000);
    queue_query(MvW'(3100), MaW'(2500));
    queue_write(5, 2, gen_mv[4][2], gen_ma[5][2], 16'd65535);
    queue_query(MvW'(3000 + 4 * 200 + 50), MaW'(2500));
    // extreme capacities at column 4 of rows 6 and 7, written in both orders
    queue_write(6, 4, 16'd3000, gen_ma[6][4], 16'd65535);
    queue_write(7, 4, 16'd3001, gen_ma[7][4], 16'd0);
    queue_query(MvW'(3000 + 6 * 200 + 150), MaW'(4000));
    queue_write(7, 4, 16'd3001, gen_ma[7][4], 16'd65535);
    queue_write(6, 4, 16'd3000, gen_ma[6][4], 16'd0);
    queue_query(MvW'(3000 + 6 * 200 + 150), MaW'(4000));
    // top corner at full scale
    queue_write(15, 0, 16'hffff, gen_ma[15][0], 16'hffff);
    queue_write(0, 15, gen_mv[0][15], 18'h3ffff, 16'hffff);
    queue_write(15, 15, 16'hffff, 18'h3ffff, 16'hffff);
    queue_query(16'hffff, 18'h3ffff);

    queue_random_items(260);
    load_random_grid();
    queue_random_items(260);
    total = pending_items.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_taken == total && cap_due.size() == 0);
    repeat (400) @(posedge clk_i);

    $display("%0d items: %0d grid writes, %0d in-grid queries, %0d below, %0d above",
             n_taken, n_wr, n_ok, n_below, n_above);
    $display("%0d results checked, %0d mismatches, %0d unexpected", n_done, n_mism,
             n_orphan);
    if (n_mism == 0 && n_orphan == 0 && cap_due.size() == 0 && n_done == total) begin
      $display("battery_capacity_bilinear_lookup_unit_tb passed");
    end else begin
      $display("battery_capacity_bilinear_lookup_unit_tb failed");
    end
    $finish;
  end

endmodule
